// File: sv/ipi_pkg.sv
// Shared types and constants for the incremental PI controller.
// No dependencies; imported by every module of the block.
package ipi_pkg;

	localparam int GAIN_W = 24;
	localparam int DATA_W = 32;
	localparam int IDX_W  = 3;
	localparam int OPD_W  = 33;
	localparam int PROD_W = 2 * OPD_W;
	localparam int ACC_W  = 60;

	localparam logic [IDX_W-1:0] REG_KP    = 3'd0;
	localparam logic [IDX_W-1:0] REG_KI    = 3'd1;
	localparam logic [IDX_W-1:0] REG_TS    = 3'd2;
	localparam logic [IDX_W-1:0] REG_UPPER = 3'd3;
	localparam logic [IDX_W-1:0] REG_LOWER = 3'd4;

	localparam logic [1:0] CLAMP_NONE = 2'd0;
	localparam logic [1:0] CLAMP_HIGH = 2'd1;
	localparam logic [1:0] CLAMP_LOW  = 2'd2;

	typedef enum logic [1:0] {
		MUL_GAIN = 2'd0,
		MUL_INT  = 2'd1,
		MUL_PROP = 2'd2
	} mul_sel_t;

	typedef struct packed {
		logic [GAIN_W-1:0] kp;
		logic [GAIN_W-1:0] ki;
		logic [GAIN_W-1:0] ts;
		logic [DATA_W-1:0] upper;
		logic [DATA_W-1:0] lower;
	} cfg_t;

	typedef struct packed {
		logic     ld_err;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     acc_init;
		logic     acc_add;
		logic     finish;
	} dp_cmd_t;

endpackage

// File: sv/ipi_cfg.sv
// Configuration register file: gains, sample period and output limits.
// Depends on ipi_pkg.
module ipi_cfg import ipi_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wen,
	input  logic [IDX_W-1:0]  index,
	input  logic [DATA_W-1:0] data,
	output cfg_t              cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.kp    <= '0;
			cfg_q.ki    <= '0;
			cfg_q.ts    <= '0;
			cfg_q.upper <= 32'h7FFF_FFFF;
			cfg_q.lower <= 32'h8000_0000;
		end else if (wen) begin
			case (index)
				REG_KP:    cfg_q.kp    <= data[GAIN_W-1:0];
				REG_KI:    cfg_q.ki    <= data[GAIN_W-1:0];
				REG_TS:    cfg_q.ts    <= data[GAIN_W-1:0];
				REG_UPPER: cfg_q.upper <= data;
				REG_LOWER: cfg_q.lower <= data;
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: sv/ipi_dp.sv
// Datapath: shared multiplier, accumulator, clamp, state and output register.
// Depends on ipi_pkg; sequenced by ipi_ctrl.
module ipi_dp import ipi_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_t              cfg,
	input  dp_cmd_t           cmd,
	input  logic [DATA_W-1:0] err_in,
	output logic [DATA_W-1:0] drive_value,
	output logic [1:0]        clamp_status
);

	localparam int Y_W = ACC_W - 16;

	logic signed [DATA_W-1:0] err_q;
	logic signed [DATA_W-1:0] prev_err_q;
	logic signed [DATA_W-1:0] prev_out_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic [DATA_W-1:0]        dout_q;
	logic [1:0]               stat_q;

	logic signed [OPD_W-1:0]  op_a;
	logic signed [OPD_W-1:0]  op_b;
	logic signed [Y_W-1:0]    y;
	logic signed [Y_W-1:0]    up_ext;
	logic signed [Y_W-1:0]    lo_ext;
	logic signed [Y_W-1:0]    y_hi;
	logic signed [Y_W-1:0]    y_cl;
	logic [1:0]               st_hi;
	logic [1:0]               st_cl;

	always_comb begin
		case (cmd.mul_sel)
			MUL_GAIN: begin
				op_a = $signed({{(OPD_W-GAIN_W){1'b0}}, cfg.ki});
				op_b = $signed({{(OPD_W-GAIN_W){1'b0}}, cfg.ts});
			end
			MUL_INT: begin
				op_a = $signed({err_q[DATA_W-1], err_q});
				op_b = $signed({1'b0, prod_q[47:16]});
			end
			MUL_PROP: begin
				op_a = $signed({err_q[DATA_W-1], err_q})
					- $signed({prev_err_q[DATA_W-1], prev_err_q});
				op_b = $signed({{(OPD_W-GAIN_W){1'b0}}, cfg.kp});
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	assign y      = acc_q[ACC_W-1:16];
	assign up_ext = $signed({{(Y_W-DATA_W){cfg.upper[DATA_W-1]}}, cfg.upper});
	assign lo_ext = $signed({{(Y_W-DATA_W){cfg.lower[DATA_W-1]}}, cfg.lower});

	always_comb begin
		y_hi  = y;
		st_hi = CLAMP_NONE;
		if (y > up_ext) begin
			y_hi  = up_ext;
			st_hi = CLAMP_HIGH;
		end
		y_cl  = y_hi;
		st_cl = st_hi;
		if (y_hi < lo_ext) begin
			y_cl  = lo_ext;
			st_cl = CLAMP_LOW;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ld_err)
			err_q <= err_in;
		if (cmd.mul_en)
			prod_q <= op_a * op_b;
		if (cmd.acc_init)
			acc_q <= $signed({{(ACC_W-56){prod_q[63]}}, prod_q[63:8]})
				+ $signed({{(ACC_W-48){prev_out_q[DATA_W-1]}}, prev_out_q, 16'd0});
		else if (cmd.acc_add)
			acc_q <= acc_q + prod_q[ACC_W-1:0];
		if (cmd.finish) begin
			dout_q <= y_cl[DATA_W-1:0];
			stat_q <= st_cl;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_err_q <= '0;
			prev_out_q <= '0;
		end else if (cmd.finish) begin
			prev_err_q <= err_q;
			prev_out_q <= y_cl[DATA_W-1:0];
		end
	end

	assign drive_value  = dout_q;
	assign clamp_status = stat_q;

endmodule

// File: sv/ipi_ctrl.sv
// Controller: one-hot sequencer over the shared multiplier, output valid flag.
// Depends on ipi_pkg; drives ipi_dp through dp_cmd_t.
module ipi_ctrl import ipi_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	output dp_cmd_t cmd
);

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_GAIN = 6'b000010,
		ST_INT  = 6'b000100,
		ST_PROP = 6'b001000,
		ST_ACC  = 6'b010000,
		ST_FIN  = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   fin_go;

	assign fin_go = (state_q == ST_FIN) && (!out_valid_q || out_ready);

	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		cmd.mul_sel  = MUL_GAIN;
		case (state_q)
			ST_IDLE: begin
				cmd.ld_err = in_valid;
				if (in_valid)
					state_d = ST_GAIN;
			end
			ST_GAIN: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_GAIN;
				state_d     = ST_INT;
			end
			ST_INT: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_INT;
				state_d     = ST_PROP;
			end
			ST_PROP: begin
				cmd.mul_en   = 1'b1;
				cmd.mul_sel  = MUL_PROP;
				cmd.acc_init = 1'b1;
				state_d      = ST_ACC;
			end
			ST_ACC: begin
				cmd.acc_add = 1'b1;
				state_d     = ST_FIN;
			end
			ST_FIN: begin
				// hold until the output register is free
				cmd.finish = fin_go;
				if (fin_go)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= fin_go || (out_valid_q && !out_ready);
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

// File: sv/incremental_pi_controller.sv
// Top level of the incremental (velocity form) PI controller.
// Depends on ipi_pkg, ipi_cfg, ipi_ctrl and ipi_dp.
//
// Usage:
//   Input stream (s_*): one signed Q16.16 error sample per transfer.
//   Output stream (m_*): one result per input, the clamped signed Q16.16
//   drive value in m_tdata and the clamp status in m_tuser
//   (0 within limits, 1 clamped high, 2 clamped low).
//   Configuration: write cfg_data to register cfg_index while cfg_wen is
//   high (0 kp, 1 ki, 2 Ts, 3 upper limit, 4 lower limit), only while idle.
// Timing:
//   A result is valid once its input has passed the states gain, integral,
//   proportional, accumulate and finish; a new input is taken once the previous
//   one leaves the sequencer. This is set by the one shared 33x33 multiplier, used
//   three times per item (ki*Ts, error*integral gain, delta error*kp).
//   A waiting result does not block the next input; if the receiver
//   stalls, the following item holds in its final step until the output
//   register is taken.
// Reset:
//   arst_n clears gains and Ts to zero, limits to full range, and the
//   stored error and output to zero.
module incremental_pi_controller import ipi_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [31:0]       s_tdata,   // [31:0] error_sample
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [31:0]       m_tdata,   // [31:0] drive_value
	output logic [1:0]        m_tuser,   // [1:0] clamp_status
	input  logic              cfg_wen,
	input  logic [IDX_W-1:0]  cfg_index,
	input  logic [DATA_W-1:0] cfg_data
);

	cfg_t    cfg;
	dp_cmd_t cmd;

	ipi_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.wen    (cfg_wen),
		.index  (cfg_index),
		.data   (cfg_data),
		.cfg    (cfg)
	);

	ipi_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.cmd       (cmd)
	);

	ipi_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.cmd          (cmd),
		.err_in       (s_tdata),
		.drive_value  (m_tdata),
		.clamp_status (m_tuser)
	);

endmodule

// File: sv/ipi_chk.sv
// Port-level checker for incremental_pi_controller, bound to the top level.
// Depends on ipi_pkg.
module ipi_chk import ipi_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              s_tvalid,
	input logic              s_tready,
	input logic              m_tvalid,
	input logic              m_tready,
	input logic [31:0]       m_tdata,
	input logic [1:0]        m_tuser
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("output transfer dropped or changed while stalled");

	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready ##1 !s_tready ##1 !s_tready ##1 !s_tready)
		else $error("input taken while an item is in flight");

	a_result_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> !$past(s_tready))
		else $error("result appeared without an item in flight");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser == CLAMP_NONE || m_tuser == CLAMP_HIGH
			|| m_tuser == CLAMP_LOW))
		else $error("undefined clamp status");

endmodule

bind incremental_pi_controller ipi_chk u_ipi_chk (.*);

// File: dv/ipi_drive_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the incremental PI controller: mirrors register writes, predicts each
// clamped drive value from the accepted error samples and compares the output stream.
// Depends on ipi_pkg for the register indexes, clamp codes and the settings record.
module ipi_drive_checker import ipi_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	input  logic              s_tready,
	input  logic [31:0]       s_tdata,
	input  logic              m_tvalid,
	input  logic              m_tready,
	input  logic [31:0]       m_tdata,
	input  logic [1:0]        m_tuser,
	input  logic              cfg_wen,
	input  logic [IDX_W-1:0]  cfg_index,
	input  logic [DATA_W-1:0] cfg_data,
	output int                mismatches,
	output int                outstanding,
	output int                checked,
	output int                high_hits,
	output int                low_hits
);

	typedef struct packed {
		logic [31:0] drive;
		logic [1:0]  status;
	} drive_result_t;

	cfg_t               settings;
	logic signed [31:0] last_error;
	logic signed [31:0] last_drive;
	drive_result_t      drive_queue[$];

	initial begin
		mismatches = 0;
		outstanding = 0;
		checked = 0;
		high_hits = 0;
		low_hits = 0;
	end

	function automatic drive_result_t next_drive(input logic signed [31:0] err);
		longint unsigned g;
		longint          pt;
		longint          it;
		longint          acc;
		longint          y;
		longint          hi;
		longint          lo;
		drive_result_t   r;
		g = ({40'd0, settings.ki} * {40'd0, settings.ts}) >> 16;
		pt = (longint'(err) - longint'(last_error)) * longint'({40'd0, settings.kp});
		it = (longint'(err) * longint'(g)) >>> 8;
		acc = pt + it + (longint'(last_drive) <<< 16);
		y = acc >>> 16;
		hi = longint'($signed(settings.upper));
		lo = longint'($signed(settings.lower));
		r.status = CLAMP_NONE;
		if (y > hi) begin
			y = hi;
			r.status = CLAMP_HIGH;
		end
		if (y < lo) begin
			y = lo;
			r.status = CLAMP_LOW;
		end
		r.drive = y[31:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		drive_result_t want;
		if (!arst_n) begin
			settings = '{kp: '0, ki: '0, ts: '0, upper: 32'h7FFF_FFFF, lower: 32'h8000_0000};
			last_error = '0;
			last_drive = '0;
			drive_queue.delete();
		end else begin
			if (cfg_wen) begin
				case (cfg_index)
					REG_KP:    settings.kp = cfg_data[GAIN_W-1:0];
					REG_KI:    settings.ki = cfg_data[GAIN_W-1:0];
					REG_TS:    settings.ts = cfg_data[GAIN_W-1:0];
					REG_UPPER: settings.upper = cfg_data;
					REG_LOWER: settings.lower = cfg_data;
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				if (drive_queue.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: unexpected result drive=%h status=%0d",
							$time, m_tdata, m_tuser);
				end else begin
					want = drive_queue.pop_front();
					checked++;
					if (m_tdata !== want.drive || m_tuser !== want.status) begin
						mismatches++;
						if (mismatches <= 10)
							$display("%0t: result %0d: expected drive=%h status=%0d, got drive=%h status=%0d",
								$time, checked, want.drive, want.status, m_tdata, m_tuser);
					end
					if (want.status == CLAMP_HIGH)
						high_hits++;
					if (want.status == CLAMP_LOW)
						low_hits++;
				end
			end
			if (s_tvalid && s_tready) begin
				want = next_drive(s_tdata);
				last_error = s_tdata;
				last_drive = want.drive;
				drive_queue.push_back(want);
			end
		end
		outstanding = drive_queue.size();
	end

endmodule

// File: dv/incremental_pi_controller_tb.sv
`timescale 1ns / 100ps
// Testbench top for incremental_pi_controller: drives error samples, register writes and
// output back-pressure, and reports the verdict. Depends on ipi_pkg and ipi_drive_checker.
module incremental_pi_controller_tb;
	import ipi_pkg::*;

	localparam int STALL_LIMIT     = 2000;
	localparam int DRAIN_CYCLES    = 12;
	localparam int RANDOM_PHASES   = 9;
	localparam int ITEMS_PER_PHASE = 150;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [31:0]       s_tdata = '0;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [31:0]       m_tdata;
	logic [1:0]        m_tuser;
	logic              cfg_wen = 1'b0;
	logic [IDX_W-1:0]  cfg_index = '0;
	logic [DATA_W-1:0] cfg_data = '0;

	bit tx_gaps = 1'b1;
	bit rx_gaps = 1'b1;
	int stall_left = 0;
	int quiet = 0;
	int sent = 0;
	int settings_loaded = 0;
	int mismatches;
	int outstanding;
	int checked;
	int high_hits;
	int low_hits;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	incremental_pi_controller DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	ipi_drive_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.cfg_wen     (cfg_wen),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.mismatches  (mismatches),
		.outstanding (outstanding),
		.checked     (checked),
		.high_hits   (high_hits),
		.low_hits    (low_hits)
	);

	always @(negedge clk) begin
		if (!rx_gaps) begin
			m_tready <= 1'b1;
		end else if (stall_left > 0) begin
			m_tready <= 1'b0;
			stall_left--;
		end else if ($urandom_range(0, 4) == 0) begin
			m_tready <= 1'b0;
			stall_left = $urandom_range(0, 4);
		end else begin
			m_tready <= 1'b1;
		end
	end

	initial begin
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet = 0;
			else
				quiet++;
		end
		$display("watchdog: no transfer for %0d cycles, %0d results still due",
			STALL_LIMIT, outstanding);
		$display("** incremental_pi_controller: FAILED **");
		$finish;
	end

	task automatic send_error(input logic [31:0] err);
		if (tx_gaps && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			s_tdata <= $urandom;
			repeat ($urandom_range(1, 5)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= err;
		do @(posedge clk); while (!s_tready);
		sent++;
		@(negedge clk);
	endtask

	// drop valid and wait until every result has been taken
	task automatic drain();
		s_tvalid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
	endtask

	task automatic load_settings(input logic [31:0] kp, ki, ts, upper, lower);
		cfg_wen <= 1'b1;
		cfg_index <= REG_KP;
		cfg_data <= kp;
		@(negedge clk);
		cfg_index <= REG_KI;
		cfg_data <= ki;
		@(negedge clk);
		cfg_index <= REG_TS;
		cfg_data <= ts;
		@(negedge clk);
		cfg_index <= REG_UPPER;
		cfg_data <= upper;
		@(negedge clk);
		cfg_index <= REG_LOWER;
		cfg_data <= lower;
		@(negedge clk);
		// unmapped index, must leave every register alone
		cfg_index <= IDX_W'(REG_LOWER + 1 + $urandom_range(0, 2));
		cfg_data <= $urandom;
		@(negedge clk);
		cfg_wen <= 1'b0;
		settings_loaded++;
	endtask

	function automatic logic [31:0] pick_gain(input logic [31:0] modest);
		case ($urandom_range(0, 5))
			0:       return '0;
			1:       return 32'h00FF_FFFF;
			2:       return $urandom;
			default: return $urandom_range(0, modest);
		endcase
	endfunction

	function automatic void pick_limits(output logic [31:0] hi, output logic [31:0] lo);
		logic [31:0] a;
		logic [31:0] b;
		a = $urandom;
		b = $urandom;
		case ($urandom_range(0, 5))
			0: begin
				hi = 32'h7FFF_FFFF;
				lo = 32'h8000_0000;
			end
			1: begin
				hi = ($signed(a) > $signed(b)) ? a : b;
				lo = ($signed(a) > $signed(b)) ? b : a;
			end
			2: begin
				hi = ($signed(a) > $signed(b)) ? b : a;
				lo = ($signed(a) > $signed(b)) ? a : b;
			end
			3: begin
				hi = a;
				lo = a;
			end
			default: begin
				a = $urandom_range(1, 32'h0100_0000);
				hi = a;
				lo = -a;
			end
		endcase
	endfunction

	function automatic logic [31:0] pick_error();
		case ($urandom_range(0, 9))
			0:       return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			1, 2, 3: return $urandom;
			default: return $urandom_range(0, 32'h00A0_0000) - 32'h0050_0000;
		endcase
	endfunction

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings: zero gains hold the output at zero
		send_error(32'h7FFF_FFFF);
		send_error(32'h8000_0000);
		send_error(32'h0000_0000);
		drain();

		// kp 1.5, ki 2.0, Ts about 1 ms, limits +/-100
		load_settings(32'h0001_8000, 32'h0002_0000, 32'h0000_4189, 32'h0064_0000, 32'hFF9C_0000);
		send_error(32'h0001_0000);
		send_error(32'hFFFF_0000);
		send_error(32'h0000_0000);
		send_error(32'h0032_0000);
		send_error(32'h00C8_0000);
		send_error(32'h00C8_0000);
		send_error(32'hFED4_0000);
		send_error(32'h7FFF_FFFF);
		send_error(32'h8000_0000);
		send_error(32'h0000_0001);
		send_error(32'hFFFF_FFFF);
		drain();

		// crossed limits: lower clamp applied last
		load_settings(32'h0001_0000, 32'h0000_0000, 32'h0000_0000, 32'hFFFB_0000, 32'h0005_0000);
		send_error(32'h000A_0000);
		send_error(32'hFFF6_0000);
		send_error(32'h0000_0000);
		drain();

		// full-scale gains and period, full-range limits
		load_settings(32'h00FF_FFFF, 32'h00FF_FFFF, 32'h00FF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
		send_error(32'h7FFF_FFFF);
		send_error(32'h8000_0000);
		send_error(32'h7FFF_FFFF);
		send_error(32'h0000_0000);
		send_error(32'h8000_0000);

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			logic [31:0] hi;
			logic [31:0] lo;
			drain();
			tx_gaps = (p != RANDOM_PHASES - 1) && (p % 3 != 1);
			rx_gaps = (p != RANDOM_PHASES - 1) && (p % 3 != 2);
			pick_limits(hi, lo);
			load_settings(pick_gain(32'h0003_0000), pick_gain(32'h0004_0000),
				pick_gain(32'h0001_0000), hi, lo);
			repeat (ITEMS_PER_PHASE) send_error(pick_error());
		end

		drain();
		repeat (DRAIN_CYCLES) @(negedge clk);
		$display("%0d error samples under %0d register settings, %0d results checked",
			sent, settings_loaded, checked);
		$display("%0d clamped high, %0d clamped low, %0d mismatches",
			high_hits, low_hits, mismatches);
		if (mismatches == 0 && outstanding == 0)
			$display("** incremental_pi_controller: PASSED **");
		else
			$display("** incremental_pi_controller: FAILED **");
		$finish;
	end

endmodule
